FILE: sv/rsas_pkg.sv
package rsas_pkg;

    // Default geometry of the element store.
    localparam int DEPTH       = 4096;
    localparam int VALUE_WIDTH = 16;

    // Width of the reported position field.
    localparam int POS_W = 12;

    // Item selector codes; selector value 3 carries no operation.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // Sequencer of the execution side.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MID,
        ST_LO,
        ST_DECIDE,
        ST_RESULT
    } t_state;

    // Address width for a store of the given depth.
    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

FILE: sv/rsas_if.sv
interface rsas_in_if #(
    parameter int VW = rsas_pkg::VALUE_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic signed [VW-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface rsas_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [rsas_pkg::POS_W-1:0]  position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

FILE: sv/rsas_ram.sv
module rsas_ram #(
    parameter int WIDTH = rsas_pkg::VALUE_WIDTH,
    parameter int DEPTH = rsas_pkg::DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [rsas_pkg::addr_w(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [rsas_pkg::addr_w(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/rsas_front.sv
module rsas_front #(
    parameter int VW = rsas_pkg::VALUE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_func,
    input  logic signed [VW-1:0] i_value,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output rsas_pkg::t_op        o_push_op,
    output logic signed [VW-1:0] o_push_value
);
    logic                 r_valid, n_valid;
    rsas_pkg::t_op        r_op, n_op;
    logic signed [VW-1:0] r_value, n_value;
    logic                 known;

    assign o_ready      = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_op    = r_op;
    assign o_push_value = r_value;

    // Decode the selector; the unused code is taken and dropped here.
    always_comb begin
        case (rsas_pkg::t_op'(i_func))
            rsas_pkg::OP_APPEND,
            rsas_pkg::OP_SEARCH,
            rsas_pkg::OP_CLEAR: known = 1'b1;
            default:            known = 1'b0;
        endcase
    end

    always_comb begin
        n_valid = r_valid && !i_push_ready;
        n_op    = r_op;
        n_value = r_value;
        if (i_valid && o_ready) begin
            n_valid = known;
            n_op    = rsas_pkg::t_op'(i_func);
            n_value = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_op    <= n_op;
        r_value <= n_value;
    end
endmodule

FILE: sv/rsas_queue.sv
module rsas_queue #(
    parameter int VW = rsas_pkg::VALUE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    output logic                 o_push_ready,
    input  rsas_pkg::t_op        i_push_op,
    input  logic signed [VW-1:0] i_push_value,
    output logic                 o_valid,
    input  logic                 i_pop,
    output rsas_pkg::t_op        o_op,
    output logic signed [VW-1:0] o_value
);
    rsas_pkg::t_op        r_op    [2];
    logic signed [VW-1:0] r_value [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    logic                 push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_valid      = (r_cnt != 2'd0);
    assign o_op         = r_op[r_rp];
    assign o_value      = r_value[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) begin
            r_op[r_wp]    <= i_push_op;
            r_value[r_wp] <= i_push_value;
        end
    end
endmodule

FILE: sv/rsas_back.sv
module rsas_back #(
    parameter int DEPTH = rsas_pkg::DEPTH,
    parameter int VW    = rsas_pkg::VALUE_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  rsas_pkg::t_op               i_q_op,
    input  logic signed [VW-1:0]        i_q_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_out_found,
    output logic [rsas_pkg::POS_W-1:0]  o_out_position
);
    localparam int AW = rsas_pkg::addr_w(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rsas_pkg::t_state r_state, n_state;

    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_lo, r_hi, r_mid, r_idx;
    logic signed [VW-1:0] r_target, r_vm;
    logic                 r_found;
    logic                 r_ovalid, r_ofound;
    logic [AW-1:0]        r_opos;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [VW-1:0]        ram_rdata;
    logic signed [VW-1:0] vb;
    logic [AW:0]          mid_sum;
    logic [AW-1:0]        mid;
    logic                 hit, go_hi, out_free, has_room;
    logic [AW+rsas_pkg::POS_W-1:0] pos_ext;

    rsas_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_q_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign vb       = signed'(ram_rdata);
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[AW:1];
    assign hit      = (r_target == r_vm);
    assign out_free = !r_ovalid || i_out_ready;
    assign has_room = (r_count < CW'(DEPTH));
    assign ram_waddr = r_count[AW-1:0];

    // Pick the half that can hold the target from the begin and middle entries.
    always_comb begin
        if (r_target < r_vm) begin
            if (vb < r_vm) begin
                go_hi = (r_target >= vb);
            end else begin
                go_hi = (vb > r_vm);
            end
        end else begin
            go_hi = (vb > r_vm) && (r_target >= vb);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rsas_pkg::ST_IDLE: begin
                if (i_q_valid && i_q_op == rsas_pkg::OP_SEARCH) begin
                    n_state = (r_count == '0) ? rsas_pkg::ST_RESULT : rsas_pkg::ST_MID;
                end
            end
            rsas_pkg::ST_MID:  n_state = rsas_pkg::ST_LO;
            rsas_pkg::ST_LO:   n_state = rsas_pkg::ST_DECIDE;
            rsas_pkg::ST_DECIDE: begin
                if (hit || (go_hi && r_mid == r_lo) || (!go_hi && r_mid == r_hi)) begin
                    n_state = rsas_pkg::ST_RESULT;
                end else begin
                    n_state = rsas_pkg::ST_MID;
                end
            end
            rsas_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = rsas_pkg::ST_IDLE;
                end
            end
            default: n_state = rsas_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = r_lo;
        case (r_state)
            rsas_pkg::ST_IDLE: begin
                o_q_pop = i_q_valid;
                ram_we  = i_q_valid && i_q_op == rsas_pkg::OP_APPEND && has_room;
            end
            rsas_pkg::ST_MID: ram_raddr = mid;
            default: ram_raddr = r_lo;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rsas_pkg::ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rsas_pkg::ST_IDLE && i_q_valid) begin
                case (i_q_op)
                    rsas_pkg::OP_APPEND: begin
                        if (has_room) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    rsas_pkg::OP_CLEAR: r_count <= '0;
                    default:            r_count <= r_count;
                endcase
            end
            if (r_state == rsas_pkg::ST_RESULT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end

        case (r_state)
            rsas_pkg::ST_IDLE: begin
                r_target <= i_q_value;
                r_lo     <= '0;
                r_hi     <= AW'(r_count - CW'(1));
                r_found  <= 1'b0;
                r_idx    <= '0;
            end
            rsas_pkg::ST_MID: r_mid <= mid;
            rsas_pkg::ST_LO:  r_vm  <= signed'(ram_rdata);
            rsas_pkg::ST_DECIDE: begin
                r_found <= hit;
                r_idx   <= hit ? r_mid : '0;
                if (go_hi) begin
                    r_hi <= r_mid - AW'(1);
                end else begin
                    r_lo <= r_mid + AW'(1);
                end
            end
            default: begin
                if (out_free) begin
                    r_ofound <= r_found;
                    r_opos   <= r_idx;
                end
            end
        endcase
    end

    assign pos_ext        = {{rsas_pkg::POS_W{1'b0}}, r_opos};
    assign o_out_valid    = r_ovalid;
    assign o_out_found    = r_ofound;
    assign o_out_position = pos_ext[rsas_pkg::POS_W-1:0];
endmodule

FILE: sv/rotated_sorted_array_search_core.sv
// Each item passes the front register and the queue; the execution side does an append or a
// clear in its idle state. A search on an empty store goes from idle to the result state; else
// each halving step runs the middle, begin and decide states, as the single read port of the
// store fetches the middle and the begin entry in turn. With 4096 entries that is at most 13
// steps. One item at a time in the execution side; intake goes on until the queue fills.
// Reset is synchronous and active low; it empties the store count and drops any pending transfer.
module rotated_sorted_array_search_core #(
    parameter int DEPTH       = rsas_pkg::DEPTH,
    parameter int VALUE_WIDTH = rsas_pkg::VALUE_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsas_in_if.sink   i_in,
    rsas_out_if.source o_out
);
    // The front stage registers each incoming transfer and decodes the selector.
    // Unknown selectors are consumed without effect, so they never reach the queue.
    logic                          f_valid, f_ready;
    rsas_pkg::t_op                 f_op;
    logic signed [VALUE_WIDTH-1:0] f_value;

    // The queue side that the execution sequencer drains.
    logic                          q_valid, q_pop;
    rsas_pkg::t_op                 q_op;
    logic signed [VALUE_WIDTH-1:0] q_value;

    rsas_front #(.VW(VALUE_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_func       (i_in.func),
        .i_value      (i_in.value),
        .o_push_valid (f_valid),
        .i_push_ready (f_ready),
        .o_push_op    (f_op),
        .o_push_value (f_value)
    );

    // A two-entry queue decouples intake from execution, so two more items, three
    // with the front register, can be taken while a long search is still walking
    // the store.
    rsas_queue #(.VW(VALUE_WIDTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_op    (f_op),
        .i_push_value (f_value),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_op         (q_op),
        .o_value      (q_value)
    );

    // The back end owns the element store and its count. Each search step reads
    // the middle entry, then the begin entry, then chooses the sorted half.
    // Results sit in an output register so the next queued items can proceed
    // while the consumer holds off, until a further result needs that register.
    rsas_back #(.DEPTH(DEPTH), .VW(VALUE_WIDTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_q_op         (q_op),
        .i_q_value      (q_value),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_found    (o_out.found),
        .o_out_position (o_out.position)
    );
endmodule

FILE: sv/rsas_checker.sv
module rsas_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_found,
    input logic [rsas_pkg::POS_W-1:0] i_out_position
);
    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transfer");

    // A miss always reports position zero.
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_position == '0)
        else $error("miss with nonzero position");

    // Reset leaves no result pending.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // Intake is open right after reset.
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");
endmodule

bind rotated_sorted_array_search_core rsas_checker u_rsas_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_found    (o_out.found),
    .i_out_position (o_out.position)
);

FILE: tb/sv/rotated_sorted_array_search_core_test.sv
module rotated_sorted_array_search_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = rsas_pkg::VALUE_WIDTH;

    // Selector value that the block has to ignore without producing an answer.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Random items after the directed part.
    localparam int RANDOM_ITEMS = 1600;

    // The receiver holds off this long once, so that the block backs up into
    // its input queue and has to stall the sender.
    localparam int HOLD_CYCLES = 400;

    // Cycles without any transfer on either channel before the run is given up.
    // The longest legal quiet stretch is the receiver hold-off above.
    localparam int STALL_LIMIT = 3000;

    // Wait after the last expected answer; it covers a search over a full store with margin.
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic                       found;
        logic [rsas_pkg::POS_W-1:0] position;
    } t_answer;

    // Keeps its own copy of the element store, works out the answer of each
    // accepted search and checks the answers that leave the block in order.
    class lookup_scoreboard;
        logic signed [VW-1:0] elements [rsas_pkg::DEPTH];
        int                   fill;
        t_answer              awaited[$];
        int                   errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // Rotated binary search: the begin and middle entries decide which half
        // is in order, and the search narrows to the half that can hold the key.
        function t_answer locate(input logic signed [VW-1:0] key);
            t_answer              ans;
            int                   lo;
            int                   hi;
            int                   mid;
            logic signed [VW-1:0] at_mid;
            logic signed [VW-1:0] at_lo;
            ans = '0;
            lo  = 0;
            hi  = fill - 1;
            while (lo <= hi && !ans.found) begin
                mid    = (lo + hi) / 2;
                at_mid = elements[mid];
                at_lo  = elements[lo];
                if (key == at_mid) begin
                    ans.found    = 1'b1;
                    ans.position = mid[rsas_pkg::POS_W-1:0];
                end else if (key < at_mid) begin
                    if (at_lo < at_mid && key >= at_lo) begin
                        hi = mid - 1;
                    end else if (at_lo > at_mid) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end else begin
                    if (at_lo > at_mid && key >= at_lo) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
            return ans;
        endfunction

        function void note_item(input logic [1:0] func, input logic signed [VW-1:0] value);
            case (func)
                rsas_pkg::OP_APPEND: begin
                    if (fill < rsas_pkg::DEPTH) begin
                        elements[fill] = value;
                        fill++;
                    end
                end
                rsas_pkg::OP_SEARCH: begin
                    awaited.push_back(locate(value));
                end
                rsas_pkg::OP_CLEAR: begin
                    fill = 0;
                end
                default: begin
                end
            endcase
        endfunction

        function void check_answer(input logic found,
                                   input logic [rsas_pkg::POS_W-1:0] position);
            t_answer exp;
            if (awaited.size() == 0) begin
                $display("%0t: answer with none expected, found %0d position %0d",
                         $time, found, position);
                errors++;
            end else begin
                exp = awaited.pop_front();
                if (found !== exp.found) begin
                    $display("%0t: found mismatch, expected %0d got %0d",
                             $time, exp.found, found);
                    errors++;
                end
                if (position !== exp.position) begin
                    $display("%0t: position mismatch, expected %0d got %0d",
                             $time, exp.position, position);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rsas_in_if #(.VW(VW)) in_ch ();
    rsas_out_if           out_ch ();

    lookup_scoreboard board;

    // Values the block currently holds, used to pick search targets that hit.
    logic signed [VW-1:0] loaded[$];

    // Number of accepted items that the block acts on.
    int sent = 0;

    // While calm is set neither side idles; hold_ask starts the one long
    // receiver hold-off, and hold_taken remembers that it has been served.
    bit calm       = 1'b0;
    bit hold_ask   = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left  = 0;

    rotated_sorted_array_search_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin : clock_gen
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // Answer side. Every accepted transfer is checked against the oldest
    // expected answer, using the values that stood before the clock edge.
    // Ready then drops at random in about a quarter of the cycles, never
    // while calm is set, and stays low for the whole hold-off once asked.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.check_answer(out_ch.found, out_ch.position);
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_ask && !hold_taken) begin
            hold_taken   <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // The run is given up when no transfer happens on either channel for a
    // long time; this is the only way the block can hang the test.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offers one item and returns at the clock edge at which it is accepted.
    // Before the offer the sender may idle for a few cycles unless calm is set.
    // Valid is lowered or raised at most once in any time step.
    task automatic send_item(input logic [1:0] func, input logic signed [VW-1:0] value);
        while (!calm && $urandom_range(0, 99) < 25) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= func;
        in_ch.value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        board.note_item(func, value);
        if (func == rsas_pkg::OP_APPEND && loaded.size() < rsas_pkg::DEPTH) begin
            loaded.push_back(value);
        end else if (func == rsas_pkg::OP_CLEAR) begin
            loaded.delete();
        end
        if (func != FUNC_UNUSED) begin
            sent++;
        end
    endtask

    // Appends n values that ascend by steps drawn from [min_step, max_step]
    // and are then rotated at a random point. A zero step gives duplicates.
    task automatic load_rotated(input int n, input int min_step, input int max_step);
        int ladder[$];
        int span;
        int base;
        int pivot;
        int top;
        top  = max_step;
        span = 0;
        if (n > 1 && top * (n - 1) > 65535) begin
            top = 65535 / (n - 1);
        end
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                span += $urandom_range(min_step, top);
            end
            ladder.push_back(span);
        end
        base  = -32768 + int'($urandom_range(0, 65535 - span));
        pivot = (n > 0) ? int'($urandom_range(0, n - 1)) : 0;
        for (int i = 0; i < n; i++) begin
            send_item(rsas_pkg::OP_APPEND, VW'(base + ladder[(i + pivot) % n]));
        end
    endtask

    // Search targets: mostly stored values, then near misses, the extremes of
    // the value range and fully random values.
    function automatic logic signed [VW-1:0] pick_target();
        int                   roll;
        logic signed [VW-1:0] t;
        roll = $urandom_range(0, 99);
        if (loaded.size() != 0 && roll < 55) begin
            t = loaded[$urandom_range(0, loaded.size() - 1)];
        end else if (loaded.size() != 0 && roll < 75) begin
            t = loaded[$urandom_range(0, loaded.size() - 1)];
            t = $urandom_range(0, 1) ? t + 1'sd1 : t - 1'sd1;
        end else if (roll < 85) begin
            t = $urandom_range(0, 1) ? {1'b0, {(VW - 1){1'b1}}} : {1'b1, {(VW - 1){1'b0}}};
        end else begin
            t = VW'($urandom);
        end
        return t;
    endfunction

    initial begin : stimulus
        int base_sent;
        int roll;
        int n;
        bit pressed;

        board   = new();
        pressed = 1'b0;

        in_ch.valid <= 1'b0;
        in_ch.func  <= rsas_pkg::OP_APPEND;
        in_ch.value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A search of the empty store, the unused selector,
        // both extremes of the value range, a search after a clear, a short
        // rotated array hit at both halves and missed, and a run with
        // duplicate values.
        send_item(rsas_pkg::OP_SEARCH, 16'sd0);
        send_item(FUNC_UNUSED, 16'sh7FFF);
        send_item(rsas_pkg::OP_APPEND, -16'sd32768);
        send_item(rsas_pkg::OP_APPEND, 16'sd32767);
        send_item(rsas_pkg::OP_SEARCH, -16'sd32768);
        send_item(rsas_pkg::OP_SEARCH, 16'sd32767);
        send_item(rsas_pkg::OP_SEARCH, 16'sd0);
        send_item(rsas_pkg::OP_CLEAR, 16'sd0);
        send_item(rsas_pkg::OP_SEARCH, -16'sd32768);
        send_item(rsas_pkg::OP_APPEND, 16'sd4);
        send_item(rsas_pkg::OP_APPEND, 16'sd7);
        send_item(rsas_pkg::OP_APPEND, -16'sd5);
        send_item(rsas_pkg::OP_APPEND, -16'sd2);
        send_item(rsas_pkg::OP_APPEND, 16'sd0);
        send_item(rsas_pkg::OP_SEARCH, 16'sd7);
        send_item(rsas_pkg::OP_SEARCH, -16'sd5);
        send_item(rsas_pkg::OP_SEARCH, 16'sd0);
        send_item(rsas_pkg::OP_SEARCH, 16'sd1);
        send_item(rsas_pkg::OP_SEARCH, 16'sd32767);
        send_item(FUNC_UNUSED, -16'sd1);
        send_item(rsas_pkg::OP_CLEAR, -16'sd1);
        send_item(rsas_pkg::OP_APPEND, 16'sd3);
        send_item(rsas_pkg::OP_APPEND, 16'sd3);
        send_item(rsas_pkg::OP_APPEND, 16'sd1);
        send_item(rsas_pkg::OP_SEARCH, 16'sd1);

        // Random part. Most blocks are a clear, a rotated ascending array of
        // random length (mostly short) and a handful of searches. The rest
        // are arrays with duplicates, unsorted arrays and loose noise items.
        // A stretch in the middle runs without idling on either side, and
        // once the receiver holds off while the sender keeps offering searches.
        base_sent = sent;
        while (sent - base_sent < RANDOM_ITEMS) begin
            calm = (sent - base_sent >= 500) && (sent - base_sent < 750);
            if (!pressed && sent - base_sent >= 1000) begin
                pressed  = 1'b1;
                hold_ask <= 1'b1;
                repeat (40) send_item(rsas_pkg::OP_SEARCH, pick_target());
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                send_item(rsas_pkg::OP_CLEAR, VW'($urandom));
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
                                                : $urandom_range(0, 24);
                load_rotated(n, 1, 2000);
                repeat ($urandom_range(2, 8)) send_item(rsas_pkg::OP_SEARCH, pick_target());
            end else if (roll < 82) begin
                send_item(rsas_pkg::OP_CLEAR, VW'($urandom));
                load_rotated($urandom_range(1, 20), 0, 3);
                repeat ($urandom_range(2, 8)) send_item(rsas_pkg::OP_SEARCH, pick_target());
            end else if (roll < 90) begin
                send_item(rsas_pkg::OP_CLEAR, VW'($urandom));
                repeat ($urandom_range(1, 16)) send_item(rsas_pkg::OP_APPEND, VW'($urandom));
                repeat ($urandom_range(2, 8)) send_item(rsas_pkg::OP_SEARCH, pick_target());
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    send_item(2'($urandom_range(0, 3)), VW'($urandom));
                end
            end
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        // Wait for every expected answer, then give the block time to show
        // any answer that should not exist.
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
